>>> rtl/wcv_pkg.sv
package wcv_pkg;

  localparam int COORD_BITS     = 16;
  localparam int HEIGHT_BITS    = 8;
  localparam int DIST_BITS      = 2 * COORD_BITS + 3;
  localparam int THR_BITS       = 16;
  localparam int COUNT_BITS     = 7;
  localparam int INDEX_BITS     = 6;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MAX_POINTS_DEF = 64;

  typedef enum logic [1:0] {
    CFG_X_ORIGIN  = 2'd0,
    CFG_Z_ORIGIN  = 2'd1,
    CFG_PT_COUNT  = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_t;

  typedef struct packed {
    logic                          action;
    logic [INDEX_BITS-1:0]         point_index;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic [HEIGHT_BITS-1:0]        pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
  } in_item_t;

  typedef struct packed {
    logic                  is_solid;
    logic [DIST_BITS-1:0]  nearest_sq;
    logic [DIST_BITS-1:0]  third_sq;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_origin;
    logic signed [COORD_BITS-1:0] z_origin;
    logic [COUNT_BITS-1:0]        point_count;
    logic [THR_BITS-1:0]          threshold;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;
    logic start;
    logic step;
    logic mul_lo;
    logic mul_hi;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic last;
    logic pipe_busy;
  } sts_t;

endpackage

>>> rtl/wcv_ctrl.sv
module wcv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_action,
  input  logic            out_stall,
  input  wcv_pkg::sts_t   sts,
  output logic            in_stall,
  output logic            out_valid,
  output wcv_pkg::cmd_t   cmd
);
  import wcv_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WALK   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_MUL_LO = 6'b001000,
    S_MUL_HI = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_CLASSIFY) begin
            cmd.start = 1'b1;
            state_nxt = S_WALK;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (sts.n_zero) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.step = 1'b1;
          if (sts.last) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/wcv_datapath.sv
module wcv_datapath #(
  parameter int MAX_POINTS = wcv_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wcv_pkg::in_item_t  in_data,
  input  wcv_pkg::cfg_t      cfg,
  input  wcv_pkg::cmd_t      cmd,
  output wcv_pkg::sts_t      sts,
  output wcv_pkg::out_item_t out_data
);
  import wcv_pkg::*;

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int NW   = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int WW   = 2 * COORD_BITS + HEIGHT_BITS;
  localparam int HI_B = DIST_BITS - 32;
  localparam int PW   = DIST_BITS + THR_BITS;

  logic [WW-1:0] mem_r [MAX_POINTS];
  logic [WW-1:0] rd_data_r;

  logic signed [COORD_BITS-1:0] vx_r, vz_r;
  logic [HEIGHT_BITS-1:0]       vy_r;
  logic [CW-1:0]                n_r, cnt_r;
  logic                         v1_r, v2_r, v3_r;

  logic [2*COORD_BITS:0]  sqx_r, sqz_r;
  logic [2*HEIGHT_BITS-1:0] sqy_r;
  logic [DIST_BITS-1:0]   dist_r;
  logic [DIST_BITS-1:0]   best1_r, best2_r, best3_r;
  logic [47:0]            plo_r;
  logic [PW-1:0]          prod_r;
  out_item_t              out_r;

  logic [NW-1:0]                n_sat;
  logic signed [COORD_BITS-1:0] px, pz;
  logic [HEIGHT_BITS-1:0]       py;
  logic signed [COORD_BITS:0]   dx, dz;
  logic signed [HEIGHT_BITS:0]  dy;
  logic [COORD_BITS:0]          ax, az;
  logic [HEIGHT_BITS-1:0]       ay;
  logic [2*COORD_BITS+1:0]      px2, pz2;
  logic [HI_B+THR_BITS-1:0]     phi;
  logic                         solid;

  always_comb begin
    if (NW'(cfg.point_count) > NW'(MAX_POINTS)) n_sat = NW'(MAX_POINTS);
    else n_sat = NW'(cfg.point_count);
  end

  assign sts.n_zero    = (n_r == '0);
  assign sts.last      = (cnt_r == n_r - CW'(1));
  assign sts.pipe_busy = v1_r || v2_r || v3_r;

  // Point memory: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (cmd.load_wr && (32'(in_data.point_index) < MAX_POINTS)) begin
      mem_r[AW'(in_data.point_index)] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    if (cmd.step) rd_data_r <= mem_r[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vx_r <= in_data.pos_x + cfg.x_origin;
      vy_r <= in_data.pos_y;
      vz_r <= in_data.pos_z + cfg.z_origin;
      n_r  <= CW'(n_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cmd.start) cnt_r <= '0;
      else if (cmd.step) cnt_r <= cnt_r + CW'(1);
      v1_r <= cmd.step;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    px  = rd_data_r[WW-1 -: COORD_BITS];
    py  = rd_data_r[COORD_BITS +: HEIGHT_BITS];
    pz  = rd_data_r[COORD_BITS-1:0];
    dx  = {px[COORD_BITS-1], px} - {vx_r[COORD_BITS-1], vx_r};
    dz  = {pz[COORD_BITS-1], pz} - {vz_r[COORD_BITS-1], vz_r};
    dy  = $signed({1'b0, py}) - $signed({1'b0, vy_r});
    ax  = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
    az  = dz[COORD_BITS] ? $unsigned(-dz) : $unsigned(dz);
    ay  = dy[HEIGHT_BITS] ? HEIGHT_BITS'($unsigned(-dy)) : HEIGHT_BITS'($unsigned(dy));
    px2 = {1'b0, ax} * {1'b0, ax};
    pz2 = {1'b0, az} * {1'b0, az};
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      sqx_r <= px2[2*COORD_BITS:0];
      sqy_r <= ay * ay;
      sqz_r <= pz2[2*COORD_BITS:0];
    end
    if (v2_r) begin
      dist_r <= DIST_BITS'(sqx_r) + DIST_BITS'(sqy_r) + DIST_BITS'(sqz_r);
    end
  end

  // Running three smallest distances; ties shift down like strict inserts.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      best1_r <= '1;
      best2_r <= '1;
      best3_r <= '1;
    end else if (v3_r) begin
      if (dist_r < best1_r) begin
        best3_r <= best2_r;
        best2_r <= best1_r;
        best1_r <= dist_r;
      end else if (dist_r < best2_r) begin
        best3_r <= best2_r;
        best2_r <= dist_r;
      end else if (dist_r < best3_r) begin
        best3_r <= dist_r;
      end
    end
  end

  // threshold * third is built from a low and a high partial product.
  assign phi = best3_r[DIST_BITS-1:32] * cfg.threshold;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) plo_r <= best3_r[31:0] * cfg.threshold;
    if (cmd.mul_hi) prod_r <= PW'(plo_r) + {phi, 32'b0};
  end

  assign solid = (n_r >= CW'(3)) && (best3_r != '0) &&
                 ({best1_r, {THR_BITS{1'b0}}} > prod_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.is_solid   <= solid;
      out_r.nearest_sq <= best1_r;
      out_r.third_sq   <= best3_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/worley_cell_voxel_classifier_core.sv
// Worley cellular noise voxel classifier.
// Input channel (in_valid / in_stall / in_data) takes two kinds of request.
// A load request writes one feature point into the point memory; loads may
// follow each other in every cycle while in_stall is low and give no result.
// A classify request offsets the voxel by the chunk origin, walks the first
// point_count stored points (saturated to MAX_POINTS) one per cycle through
// the single read port of the point memory, and keeps the three nearest.
// Its result appears on out_valid / out_data after the walk, the pipeline drain
// and the low and high product steps; in_stall stays high until it is stored.
// The point memory read port sets the walk length, one point a cycle.
// The result sits in an output register, so a new request is accepted while
// a result still waits; a stalled result holds, and a later classify waits in
// its last step until the output register is free. The user writes configuration
// (cfg_we / cfg_index / cfg_wdata) only while idle; the block does not enforce
// this. Reset clears the control state and the configuration to its defaults;
// the point memory is not cleared and must be loaded before it is walked.
module worley_cell_voxel_classifier_core #(
  parameter int MAX_POINTS = wcv_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wcv_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wcv_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  wcv_pkg::cfg_idx_t                    cfg_index,
  input  logic [wcv_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import wcv_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_ORIGIN:  cfg_nxt.x_origin    = cfg_wdata;
        CFG_Z_ORIGIN:  cfg_nxt.z_origin    = cfg_wdata;
        CFG_PT_COUNT:  cfg_nxt.point_count = cfg_wdata[COUNT_BITS-1:0];
        CFG_THRESHOLD: cfg_nxt.threshold   = cfg_wdata[THR_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin    <= '0;
      cfg_r.z_origin    <= '0;
      cfg_r.point_count <= '0;
      cfg_r.threshold   <= THR_BITS'(32768);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  wcv_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // A classify request closes the input until its result is stored.
  a_classify_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.action == ACT_CLASSIFY) |=> in_stall)
    else $error("input not blocked after classify request");

  // The output register is loaded only when it is empty or being taken.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // The product starts only after the distance pipeline has drained.
  a_mul_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_lo |-> !sts.pipe_busy)
    else $error("product started with distances in flight");

  // A result is produced only while the input side is closed.
  a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> in_stall)
    else $error("result stored while idle");

endmodule

>>> test/tb_worley_cell_voxel_classifier_core.sv
`timescale 1ns / 1ps

module tb_worley_cell_voxel_classifier_core;
  import wcv_pkg::*;

  localparam int RANDOM_REQUESTS = 1650;
  localparam int SLOTS = MAX_POINTS_DEF;
  localparam int SETTLE_CYCLES = SLOTS + 16;
  localparam longint unsigned DIST_ONES = (64'd1 << DIST_BITS) - 64'd1;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Mirrors the point store and the registers, and predicts the three-nearest search.
  class nearest_scoreboard;
    logic signed [COORD_BITS-1:0] pt_x [SLOTS];
    logic [HEIGHT_BITS-1:0]       pt_y [SLOTS];
    logic signed [COORD_BITS-1:0] pt_z [SLOTS];
    logic signed [COORD_BITS-1:0] x_origin;
    logic signed [COORD_BITS-1:0] z_origin;
    logic [COUNT_BITS-1:0]        point_count;
    logic [THR_BITS-1:0]          threshold;
    out_item_t                    pending_results [$];
    int                           mismatches;
    int                           results_seen;

    function new();
      x_origin = '0;
      z_origin = '0;
      point_count = '0;
      threshold = 16'h8000;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_X_ORIGIN: x_origin = val;
        CFG_Z_ORIGIN: z_origin = val;
        CFG_PT_COUNT: point_count = val[COUNT_BITS-1:0];
        default: threshold = val;
      endcase
    endfunction

    function out_item_t classify_voxel(in_item_t req);
      logic [COORD_BITS-1:0] wx, wz;
      longint vx, vy, vz, dx, dy, dz;
      longint unsigned d, b1, b2, b3;
      int n;
      out_item_t res;
      // The origin offset wraps at the coordinate width.
      wx = req.pos_x + x_origin;
      wz = req.pos_z + z_origin;
      vx = $signed(wx);
      vy = req.pos_y;
      vz = $signed(wz);
      n = (point_count > SLOTS) ? SLOTS : point_count;
      b1 = DIST_ONES;
      b2 = DIST_ONES;
      b3 = DIST_ONES;
      for (int i = 0; i < n; i++) begin
        dx = pt_x[i] - vx;
        dy = longint'(pt_y[i]) - vy;
        dz = pt_z[i] - vz;
        d = dx * dx + dy * dy + dz * dz;
        if (d < b1) begin
          b3 = b2;
          b2 = b1;
          b1 = d;
        end else if (d < b2) begin
          b3 = b2;
          b2 = d;
        end else if (d < b3) begin
          b3 = d;
        end
      end
      res.is_solid = (n >= 3) && (b3 != 0) && ((b1 << 16) > b3 * threshold);
      res.nearest_sq = b1[DIST_BITS-1:0];
      res.third_sq = b3[DIST_BITS-1:0];
      return res;
    endfunction

    function void note_request(in_item_t req);
      if (req.action == ACT_LOAD) begin
        pt_x[req.point_index] = req.pos_x;
        pt_y[req.point_index] = req.pos_y;
        pt_z[req.point_index] = req.pos_z;
      end else begin
        pending_results.push_back(classify_voxel(req));
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.is_solid !== want.is_solid)
        report($sformatf("result %0d is_solid %b, want %b",
                         results_seen, got.is_solid, want.is_solid));
      if (got.nearest_sq !== want.nearest_sq)
        report($sformatf("result %0d nearest_sq %0d, want %0d",
                         results_seen, got.nearest_sq, want.nearest_sq));
      if (got.third_sq !== want.third_sq)
        report($sformatf("result %0d third_sq %0d, want %0d",
                         results_seen, got.third_sq, want.third_sq));
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_X_ORIGIN;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  nearest_scoreboard sb = new();

  bit slot_loaded [SLOTS];
  int burst_left = 0;
  int items_sent = 0;
  logic [COORD_BITS-1:0] ctr_x = '0;
  logic [COORD_BITS-1:0] ctr_z = '0;
  logic [HEIGHT_BITS-1:0] ctr_y = '0;
  int spread = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_span = 0;
  int stall_tick = 0;

  worley_cell_voxel_classifier_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  // The receiver switches between random stall patterns (none, light, heavy, periodic).
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(50, 400);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE: out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = (stall_tick % 4 != 0);
    endcase
  end

  task automatic send_request(in_item_t req);
    @(negedge clk);
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(req);
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Loads give no result, so after the last result the block is left to settle
  // before its registers change.
  task automatic apply_config(logic [15:0] xo, logic [15:0] zo, logic [6:0] cnt,
                              logic [15:0] thr);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_X_ORIGIN, xo);
    write_reg(CFG_Z_ORIGIN, zo);
    write_reg(CFG_PT_COUNT, {9'($urandom), cnt});
    write_reg(CFG_THRESHOLD, thr);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic pace();
    int gap;
    int r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 29) == 0) begin
        drain_results();
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3)
          gap = 0;
        else if (r == 9)
          gap = $urandom_range(13, 90);
        else
          gap = $urandom_range(1, 12);
        if (gap > 0)
          idle_gap(gap);
      end
    end
    burst_left--;
  endtask

  function automatic in_item_t voxel_req(action_t act, int slot, int x, int y, int z);
    in_item_t req;
    req.action = act;
    req.point_index = 6'(slot);
    req.pos_x = 16'(x);
    req.pos_y = 8'(y);
    req.pos_z = 16'(z);
    if (act == ACT_LOAD)
      slot_loaded[slot] = 1'b1;
    return req;
  endfunction

  function automatic logic [15:0] pick_coord(logic [15:0] center);
    if (spread == 0 || $urandom_range(0, 19) == 0)
      return 16'($urandom);
    return center + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
  endfunction

  function automatic logic [15:0] pick_origin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return 16'h8000;
    if (r < 30)
      return 16'h7fff;
    if (r < 40)
      return 16'h0000;
    return 16'($urandom);
  endfunction

  // A classify may only walk slots that hold a point, so a missing slot below the
  // count is filled first.
  function automatic in_item_t next_request();
    in_item_t req;
    int n;
    int missing;
    logic [15:0] wx, wz;
    n = (sb.point_count > SLOTS) ? SLOTS : sb.point_count;
    missing = -1;
    for (int j = n - 1; j >= 0; j--)
      if (!slot_loaded[j])
        missing = j;
    req.point_index = 6'($urandom);
    if (spread == 0 || $urandom_range(0, 3) == 0)
      req.pos_y = 8'($urandom);
    else
      req.pos_y = ctr_y + 8'($urandom_range(0, 16)) - 8'd8;
    wx = pick_coord(ctr_x);
    wz = pick_coord(ctr_z);
    if (missing < 0 && $urandom_range(0, 99) < 55) begin
      req.action = ACT_CLASSIFY;
      req.pos_x = wx - sb.x_origin;
      req.pos_z = wz - sb.z_origin;
    end else begin
      req.action = ACT_LOAD;
      if (missing >= 0)
        req.point_index = 6'(missing);
      else if (n > 0 && $urandom_range(0, 9) < 7)
        req.point_index = 6'($urandom_range(0, n - 1));
      req.pos_x = wx;
      req.pos_z = wz;
      slot_loaded[req.point_index] = 1'b1;
    end
    return req;
  endfunction

  initial begin
    int r;
    int phase;
    logic [6:0] cnt;
    logic [15:0] thr;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // With no points the distances stay all ones.
    send_request(voxel_req(ACT_CLASSIFY, 63, 0, 0, 0));
    send_request(voxel_req(ACT_LOAD, 0, -32768, 0, -32768));
    send_request(voxel_req(ACT_LOAD, 1, -32768, 0, -32768));
    send_request(voxel_req(ACT_LOAD, 2, -32768, 0, -32768));
    send_request(voxel_req(ACT_LOAD, 3, 32767, 255, 32767));
    send_request(voxel_req(ACT_LOAD, 63, 1234, 77, -4321));

    // Two points are too few to decide solidity.
    apply_config(16'h0000, 16'h0000, 7'd2, 16'h8000);
    send_request(voxel_req(ACT_CLASSIFY, 0, -32768, 0, -32768));

    // Three coincident points give a zero third distance.
    apply_config(16'h0000, 16'h0000, 7'd3, 16'h8000);
    send_request(voxel_req(ACT_CLASSIFY, 5, -32768, 0, -32768));

    // The origin wraps the voxel position around the coordinate range.
    apply_config(16'h7fff, 16'h7fff, 7'd4, 16'h0000);
    send_request(voxel_req(ACT_CLASSIFY, 9, 1, 128, 1));
    send_request(voxel_req(ACT_CLASSIFY, 9, 0, 255, 0));

    // Equal nearest and third distances still beat the largest threshold.
    apply_config(16'h8000, 16'h8000, 7'd4, 16'hffff);
    send_request(voxel_req(ACT_CLASSIFY, 17, 0, 128, 0));
    send_request(voxel_req(ACT_CLASSIFY, 42, -1, 0, -1));

    phase = 0;
    while (items_sent < RANDOM_REQUESTS) begin
      r = $urandom_range(0, 99);
      if (phase == 0)
        cnt = 7'd127;
      else if (phase == 1)
        cnt = 7'd64;
      else if (r < 8)
        cnt = 7'd0;
      else if (r < 14)
        cnt = 7'd1;
      else if (r < 20)
        cnt = 7'd2;
      else if (r < 28)
        cnt = 7'd3;
      else if (r < 34)
        cnt = 7'd64;
      else if (r < 40)
        cnt = 7'($urandom_range(65, 127));
      else if (r < 75)
        cnt = 7'($urandom_range(3, 10));
      else
        cnt = 7'($urandom_range(0, 64));
      r = $urandom_range(0, 99);
      if (r < 15)
        thr = 16'h0000;
      else if (r < 30)
        thr = 16'hffff;
      else if (r < 40)
        thr = 16'h8000;
      else
        thr = 16'($urandom);
      apply_config(pick_origin(), pick_origin(), cnt, thr);

      ctr_x = 16'($urandom);
      ctr_z = 16'($urandom);
      ctr_y = 8'($urandom);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 4;
        2: spread = 64;
        default: spread = 3000;
      endcase

      repeat ($urandom_range(30, 120)) begin
        pace();
        send_request(next_request());
        items_sent++;
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report("results still pending at end of run");
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
